@@ rtl/aob_pkg.sv @@
// ----------------------------------------------------------------------------
// ARGB source-over blend with fade: shared package
// Pixel widths, pipeline stage types and the fixed-point helpers used by the
// blend pipeline and its channel interfaces.
// ----------------------------------------------------------------------------
package aob_pkg;

  localparam int unsigned PixW   = 32;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned SumW   = 9;   // premultiplied sum or composite alpha
  localparam int unsigned NumW   = 18;  // c * 255 + a / 2 with room to spare
  localparam int unsigned NumCh  = 3;   // red, green, blue

  localparam logic [ChanW-1:0] ChanMax = 8'hff;

  typedef logic [PixW-1:0]  pix_t;
  typedef logic [ChanW-1:0] chan_t;
  typedef logic [SumW-1:0]  sum_t;
  typedef logic [NumW-1:0]  num_t;

  // Stage 1: faded source alpha and premultiplied destination.
  typedef struct packed {
    logic                   pass;
    pix_t                   pix;
    chan_t                  sa;
    chan_t                  da;
    logic [NumCh-1:0][ChanW-1:0] dc;
    logic [NumCh-1:0][ChanW-1:0] sc;
  } s1_t;

  // Stage 2: composited premultiplied color and alpha.
  typedef struct packed {
    logic                       pass;
    pix_t                       pix;
    sum_t                       a;
    logic [NumCh-1:0][SumW-1:0] c;
  } s2_t;

  // One restoring divider lane.
  typedef struct packed {
    num_t  rem;
    chan_t q;
  } div_t;

  // Divider stages: three lanes share the composite alpha as divisor.
  typedef struct packed {
    logic             pass;
    pix_t             pix;
    sum_t             a;
    logic [NumCh-1:0] sat;
    div_t [NumCh-1:0] d;
  } dv_t;

  // ((x + 1) * 257) >> 16 for x up to 255 * 255; the result fits in 8 bits.
  function automatic chan_t div255(input logic [15:0] x);
    logic [16:0] y;
    logic [24:0] p;
    y = {1'b0, x} + 17'd1;
    p = {y, 8'b0} + {8'b0, y};
    return p[23:16];
  endfunction

  // One quotient bit of a restoring division.
  function automatic div_t div_bit(input div_t d, input sum_t a, input logic [2:0] k);
    num_t  trial;
    div_t  r;
    trial = num_t'(a) << k;
    r     = d;
    if (d.rem >= trial) begin
      r.rem  = d.rem - trial;
      r.q[k] = 1'b1;
    end
    return r;
  endfunction

endpackage

@@ rtl/aob_if.sv @@
// ----------------------------------------------------------------------------
// ARGB blend channel interfaces
// Valid/ready channels for the pixel pair going in and the blended pixel out.
// ----------------------------------------------------------------------------
interface aob_in_if import aob_pkg::*; ();
  logic valid;
  logic ready;
  pix_t dest_pixel;
  pix_t source_pixel;

  modport source (output valid, output dest_pixel, output source_pixel, input ready);
  modport sink   (input valid, input dest_pixel, input source_pixel, output ready);
endinterface

interface aob_out_if import aob_pkg::*; ();
  logic valid;
  logic ready;
  pix_t blended_pixel;

  modport source (output valid, output blended_pixel, input ready);
  modport sink   (input valid, input blended_pixel, output ready);
endinterface

@@ rtl/argb_over_blend_with_fade_core.sv @@
// ----------------------------------------------------------------------------
// ARGB source-over blend with fade
// Seven-stage pipeline: fade and destination premultiply, source-over
// composite, numerator build, then a three-lane restoring divider that
// un-premultiplies two quotient bits per stage.
// Throughput: one word per cycle while out_o.ready holds; a stage moves when it
// is empty or the next one moves. Reset clears the valid bits, fade goes to 255.
// ----------------------------------------------------------------------------
module argb_over_blend_with_fade_core import aob_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fade_level_we_i,
  input  logic [ChanW-1:0] fade_level_i,
  aob_in_if.sink           in_i,
  aob_out_if.source        out_o
);

  localparam int unsigned NumStg = 7;
  localparam int unsigned NumDv  = 4;

  chan_t             fade_q;
  logic [NumStg-1:0] v_q;
  logic [NumStg-1:0] en;

  s1_t   s1_d, s1_q;
  s2_t   s2_d, s2_q;
  dv_t   dv_d [NumDv];
  dv_t   dv_q [NumDv];
  pix_t  out_d, out_q;

  // Fade register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_q <= ChanMax;
    end else if (fade_level_we_i) begin
      fade_q <= fade_level_i;
    end
  end

  // Stage enables: a stage loads when it is empty or its successor loads.
  always_comb begin
    en[NumStg-1] = !v_q[NumStg-1] || out_o.ready;
    for (int k = NumStg - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NumStg; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_i.ready          = en[0];
  assign out_o.valid         = v_q[NumStg-1];
  assign out_o.blended_pixel = out_q;

  // Stage 1: fade the source alpha, pick a pass-through pixel, premultiply
  // the destination.
  always_comb begin
    s1_d.sa = div255(16'(in_i.source_pixel[31:24]) * 16'(fade_q));
    s1_d.da = in_i.dest_pixel[31:24];
    s1_d.sc = in_i.source_pixel[23:0];
    s1_d.pass = (s1_d.sa == ChanMax) || (s1_d.sa == '0);
    s1_d.pix  = (s1_d.sa == ChanMax) ? in_i.source_pixel : in_i.dest_pixel;
    for (int c = 0; c < NumCh; c++) begin
      s1_d.dc[c] = div255(16'(in_i.dest_pixel[c*ChanW +: ChanW]) * 16'(s1_d.da));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) s1_q <= s1_d;
  end

  // Stage 2: source-over on premultiplied values.
  always_comb begin
    chan_t ia;
    ia        = ChanMax - s1_q.sa;
    s2_d.pass = s1_q.pass;
    s2_d.pix  = s1_q.pix;
    s2_d.a    = sum_t'(s1_q.sa) + sum_t'(div255(16'(s1_q.da) * 16'(ia)));
    for (int c = 0; c < NumCh; c++) begin
      s2_d.c[c] = sum_t'(div255(16'(s1_q.sc[c]) * 16'(s1_q.sa)))
                + sum_t'(div255(16'(s1_q.dc[c]) * 16'(ia)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) s2_q <= s2_d;
  end

  // Stage 3: numerator c * 255 + a / 2 and the saturation test against a * 256.
  always_comb begin
    num_t n;
    dv_d[0].pass = s2_q.pass;
    dv_d[0].pix  = s2_q.pix;
    dv_d[0].a    = s2_q.a;
    for (int c = 0; c < NumCh; c++) begin
      n = num_t'({s2_q.c[c], 8'b0}) - num_t'(s2_q.c[c])
        + num_t'(s2_q.a[SumW-1:1]);
      dv_d[0].d[c].rem = n;
      dv_d[0].d[c].q   = '0;
      dv_d[0].sat[c]   = n >= (num_t'(s2_q.a) << 8);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) dv_q[0] <= dv_d[0];
  end

  // Divider stages: two quotient bits each, most significant first.
  for (genvar j = 1; j < NumDv; j++) begin : g_div
    always_comb begin
      dv_d[j] = dv_q[j-1];
      for (int c = 0; c < NumCh; c++) begin
        dv_d[j].d[c] = div_bit(dv_q[j-1].d[c], dv_q[j-1].a, 3'(9 - 2 * j));
        dv_d[j].d[c] = div_bit(dv_d[j].d[c], dv_q[j-1].a, 3'(8 - 2 * j));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[2+j]) dv_q[j] <= dv_d[j];
    end
  end

  // Last stage: the two low quotient bits, saturation and pixel assembly.
  always_comb begin
    div_t  t;
    out_d = {dv_q[NumDv-1].a[ChanW-1:0], 24'b0};
    for (int c = 0; c < NumCh; c++) begin
      t = div_bit(dv_q[NumDv-1].d[c], dv_q[NumDv-1].a, 3'd1);
      t = div_bit(t, dv_q[NumDv-1].a, 3'd0);
      out_d[c*ChanW +: ChanW] = dv_q[NumDv-1].sat[c] ? ChanMax : t.q;
    end
    if (dv_q[NumDv-1].pass) begin
      out_d = dv_q[NumDv-1].pix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NumStg-1]) out_q <= out_d;
  end

endmodule

@@ bench/argb_over_blend_with_fade_core_tb.sv @@
// ----------------------------------------------------------------------------
// ARGB source-over blend with fade: testbench
// Drives pixel pairs through the valid/ready input channel. It starts with a
// table of directed pixels and fade levels, then runs phases of random pixels
// under several fade levels. Each blended word is checked against its table
// word or a local fixed-point model of the blend. Both sides idle at random
// in the early phases and run flat out in the last ones.
// ----------------------------------------------------------------------------
module argb_over_blend_with_fade_core_tb;
  import aob_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainLimit  = 2000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned NumPhases   = 7;
  localparam int unsigned PhaseItems  = 200;
  localparam int unsigned NumDirRows  = 21;

  typedef struct {
    chan_t fade;
    pix_t  dst;
    pix_t  src;
    bit    known;
    pix_t  blended;
  } pixel_row_t;

  // Rows marked known carry a blended word that follows directly from the
  // pass-through rules; the others are checked against the local model.
  pixel_row_t dir_rows [NumDirRows] = '{
    '{8'hff, 32'h80abcdef, 32'hff123456, 1'b1, 32'hff123456},
    '{8'hff, 32'h12345678, 32'h00ffffff, 1'b1, 32'h12345678},
    '{8'hff, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000},
    '{8'hff, 32'hffffffff, 32'hffffffff, 1'b1, 32'hffffffff},
    '{8'hff, 32'hffffffff, 32'h01000000, 1'b0, 32'h0},
    '{8'hff, 32'h00000000, 32'h01ffffff, 1'b0, 32'h0},
    '{8'hff, 32'hff000000, 32'hfeffffff, 1'b0, 32'h0},
    '{8'hff, 32'h80ff00ff, 32'h8000ff00, 1'b0, 32'h0},
    '{8'hff, 32'h00ffffff, 32'h7f808080, 1'b0, 32'h0},
    '{8'hff, 32'hffffffff, 32'h80ffffff, 1'b0, 32'h0},
    '{8'hff, 32'h01ffffff, 32'h02ffffff, 1'b0, 32'h0},
    '{8'h00, 32'h80abcdef, 32'hff123456, 1'b1, 32'h80abcdef},
    '{8'h00, 32'hffffffff, 32'hffffffff, 1'b1, 32'hffffffff},
    '{8'h00, 32'h00000000, 32'h80ffffff, 1'b1, 32'h00000000},
    '{8'h01, 32'h00000000, 32'hffffffff, 1'b0, 32'h0},
    '{8'h01, 32'hffffffff, 32'hff000000, 1'b0, 32'h0},
    '{8'h80, 32'h55aa55aa, 32'hffff0000, 1'b0, 32'h0},
    '{8'h80, 32'hff00ff00, 32'h01ffffff, 1'b1, 32'hff00ff00},
    '{8'hfe, 32'h12345678, 32'hffabcdef, 1'b0, 32'h0},
    '{8'hfe, 32'haaaaaaaa, 32'h55555555, 1'b0, 32'h0},
    '{8'hff, 32'h7fffffff, 32'h80000000, 1'b0, 32'h0}
  };

  logic  clk;
  logic  rst_n;
  logic  fade_we;
  chan_t fade_val;

  aob_in_if  in_bus ();
  aob_out_if out_bus ();

  argb_over_blend_with_fade_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .fade_level_we_i (fade_we),
    .fade_level_i    (fade_val),
    .in_i            (in_bus),
    .out_o           (out_bus)
  );

  pix_t        expected_blend [$];
  chan_t       fade_now;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CycleLimit);
    $display("Timeout after %0d cycles, %0d words outstanding", CycleLimit,
             expected_blend.size());
    $display("Verification failed");
    $finish;
  end

  // ((x + 1) * 257) >> 16, the divide-by-255 approximation.
  function automatic int unsigned approx_div255(input int unsigned x);
    return ((x + 1) * 257) >> 16;
  endfunction

  // Un-premultiply with rounding and saturate at full scale.
  function automatic chan_t to_straight(input int unsigned c, input int unsigned a);
    int unsigned v;
    if (a == 0) return '0;
    v = (c * 255 + a / 2) / a;
    if (v > 255) v = 255;
    return chan_t'(v);
  endfunction

  function automatic pix_t predict_blend(input pix_t dst, input pix_t src, input chan_t fade);
    int unsigned sa, da, ia, comp_a, sc, dc, mix;
    pix_t        res;
    sa = approx_div255(32'(src[31:24]) * 32'(fade));
    if (sa == 255) return src;
    if (sa == 0) return dst;
    da     = 32'(dst[31:24]);
    ia     = 255 - sa;
    comp_a = sa + approx_div255(da * ia);
    res[31:24] = comp_a[7:0];
    for (int i = 0; i < 3; i++) begin
      dc  = approx_div255(32'(dst[8*i +: 8]) * da);
      sc  = approx_div255(32'(src[8*i +: 8]) * sa);
      mix = sc + approx_div255(dc * ia);
      res[8*i +: 8] = to_straight(mix, comp_a);
    end
    return res;
  endfunction

  // Alphas lean toward the pass-through and near-edge values.
  function automatic pix_t random_pixel();
    chan_t       a;
    logic [23:0] rgb;
    case ($urandom_range(0, 7))
      0:       a = 8'h00;
      1:       a = 8'hff;
      2:       a = chan_t'($urandom_range(1, 4));
      3:       a = chan_t'($urandom_range(251, 254));
      default: a = chan_t'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       rgb = 24'h000000;
      1:       rgb = 24'hffffff;
      default: rgb = 24'($urandom);
    endcase
    return {a, rgb};
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high so back-to-back words need no bubble.
  task automatic send_pixel(input pix_t dst, input pix_t src, input bit known,
                            input pix_t typed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid        = 1'b1;
    in_bus.dest_pixel   = dst;
    in_bus.source_pixel = src;
    do @(posedge clk); while (!in_bus.ready);
    expected_blend.push_back(known ? typed : predict_blend(dst, src, fade_now));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_bus.valid = 1'b0;
    while (expected_blend.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Only called with the pipeline empty.
  task automatic write_fade(input chan_t level);
    fade_we  = 1'b1;
    fade_val = level;
    @(negedge clk);
    fade_we  = 1'b0;
    fade_now = level;
  endtask

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_blend.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", out_bus.blended_pixel));
      end else if (out_bus.blended_pixel !== expected_blend[0]) begin
        report_mismatch($sformatf("blended_pixel %h, expected %h",
                                  out_bus.blended_pixel, expected_blend[0]));
        void'(expected_blend.pop_front());
      end else begin
        void'(expected_blend.pop_front());
      end
    end
  end

  initial begin
    int unsigned drain_cycles;
    chan_t       level;
    mismatch_count      = 0;
    rst_n               = 1'b0;
    fade_we             = 1'b0;
    fade_val            = 8'hff;
    fade_now            = 8'hff;
    in_bus.valid        = 1'b0;
    in_bus.dest_pixel   = '0;
    in_bus.source_pixel = '0;
    send_idle_pct       = 24;
    recv_idle_pct       = 56;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].fade != fade_now) begin
        wait_drained();
        write_fade(dir_rows[r].fade);
      end
      send_pixel(dir_rows[r].dst, dir_rows[r].src, dir_rows[r].known,
                 dir_rows[r].blended);
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      if (p < 2) begin
        send_idle_pct = 24;
        recv_idle_pct = 56;
      end else if (p < 4) begin
        send_idle_pct = 56;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        1:       level = 8'hff;
        2:       level = 8'h00;
        4:       level = 8'h01;
        5:       level = 8'hfe;
        default: level = chan_t'($urandom_range(2, 253));
      endcase
      write_fade(level);
      for (int n = 0; n < PhaseItems; n++) begin
        send_pixel(random_pixel(), random_pixel(), 1'b0, '0);
      end
    end

    in_bus.valid = 1'b0;
    drain_cycles = 0;
    while (expected_blend.size() != 0 && drain_cycles < DrainLimit) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (expected_blend.size() != 0) begin
      report_mismatch($sformatf("%0d blended words never arrived",
                                expected_blend.size()));
    end
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
